/* rtl/psd_pkg.sv */
// Shared types, codes and constants of the PDF string token decoder.
package psd_pkg;

  // Decoder mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_HEX  = 2'd2
  } mode_t;

  // Result kind
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_REJ  = 2'd2
  } kind_t;

  // Input item
  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       last;
  } res_t;

  // Queue entry: the one or two results caused by one input item
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } qentry_t;

  // Defaults
  localparam int MAX_NEST_DEF = 255;
  localparam int QDEPTH       = 4;

  // Action codes
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Delimiters and escape characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  // Control bytes produced by the named escapes
  localparam logic [7:0] BY_LF  = 8'h0A;
  localparam logic [7:0] BY_CR  = 8'h0D;
  localparam logic [7:0] BY_TAB = 8'h09;
  localparam logic [7:0] BY_BS  = 8'h08;
  localparam logic [7:0] BY_FF  = 8'h0C;

  // Build one result
  function automatic res_t mk_res(kind_t k, logic [7:0] b);
    res_t r;
    r.kind     = k;
    r.out_byte = b;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/psd_stream_if.sv */
// Valid/ready stream channel carrying one payload item per transaction.
interface psd_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/psd_front.sv */
// Front end: accepts input bytes, runs the token state machine, queues results.
module psd_front import psd_pkg::*; #(
  parameter int MAX_NEST = MAX_NEST_DEF
) (
  input  logic          clk,
  input  logic          rst,
  psd_stream_if.sink    in_tok,
  input  logic          q_full,
  output logic          q_push,
  output qentry_t       q_data
);

  localparam int DW = $clog2(MAX_NEST + 1);
  localparam logic [DW-1:0] MAX_D = DW'(MAX_NEST);
  localparam logic [DW-1:0] ONE_D = DW'(1);

  mode_t         mode, mode_next;
  logic [DW-1:0] depth, depth_next;
  logic          esc, esc_next;
  logic [1:0]    odig, odig_next;
  logic [7:0]    oval, oval_next;
  logic [3:0]    hi, hi_next;
  logic          pend, pend_next;

  logic          accept;
  logic [1:0]    cnt;
  res_t          res [2];
  logic          done;
  logic          clr;
  logic [DW-1:0] dec;
  logic [4:0]    hv;
  logic          flush;
  logic [7:0]    b;

  function automatic logic is_white(logic [7:0] c);
    return c inside {8'h00, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20};
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return c inside {[CH_0:CH_7]};
  endfunction

  // Hex digit value in the low nibble, bit 4 set for a non-hex byte
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    case (c) inside
      [CH_0:CH_9]:   v = {1'b0, c[3:0]};
      [CH_LA:CH_LF],
      [CH_UA:CH_UF]: v = {1'b0, 4'(c[3:0] + 4'd9)};
      default:       v = 5'h10;
    endcase
    return v;
  endfunction

  assign flush     = (in_tok.data.action == ACT_FLUSH);
  assign b         = in_tok.data.in_byte;
  assign in_tok.ready = !q_full;
  assign accept    = in_tok.valid && in_tok.ready;

  // Next state and results of the current byte
  always_comb begin
    mode_next  = mode;
    depth_next = depth;
    esc_next   = esc;
    odig_next  = odig;
    oval_next  = oval;
    hi_next    = hi;
    pend_next  = pend;
    cnt        = 2'd0;
    res[0]     = mk_res(KIND_BYTE, 8'h00);
    res[1]     = mk_res(KIND_BYTE, 8'h00);
    done       = 1'b0;
    clr        = 1'b0;
    dec        = '0;
    hv         = hex_val(b);
    case (mode)
      MODE_LIT: begin
        if (flush) begin
          // flush a pending octal escape, drop a dangling backslash
          if (odig != 2'd0) begin
            res[cnt[0]] = mk_res(KIND_BYTE, oval);
            cnt = cnt + 2'd1;
          end
          res[cnt[0]] = mk_res(KIND_END, 8'h00);
          cnt = cnt + 2'd1;
          clr = 1'b1;
        end else begin
          // octal escape in progress
          if (odig != 2'd0) begin
            if (is_octal(b)) begin
              oval_next = {oval[4:0], b[2:0]};
              done = 1'b1;
              if (odig == 2'd2) begin
                res[cnt[0]] = mk_res(KIND_BYTE, oval_next);
                cnt = cnt + 2'd1;
                odig_next = 2'd0;
                oval_next = 8'h00;
              end else begin
                odig_next = odig + 2'd1;
              end
            end else begin
              res[cnt[0]] = mk_res(KIND_BYTE, oval);
              cnt = cnt + 2'd1;
              odig_next = 2'd0;
              oval_next = 8'h00;
            end
          end
          if (!done) begin
            if (esc) begin
              // escaped character
              esc_next = 1'b0;
              case (b)
                CH_N: begin res[cnt[0]] = mk_res(KIND_BYTE, BY_LF);  cnt = cnt + 2'd1; end
                CH_R: begin res[cnt[0]] = mk_res(KIND_BYTE, BY_CR);  cnt = cnt + 2'd1; end
                CH_T: begin res[cnt[0]] = mk_res(KIND_BYTE, BY_TAB); cnt = cnt + 2'd1; end
                CH_B: begin res[cnt[0]] = mk_res(KIND_BYTE, BY_BS);  cnt = cnt + 2'd1; end
                CH_F: begin res[cnt[0]] = mk_res(KIND_BYTE, BY_FF);  cnt = cnt + 2'd1; end
                default: begin
                  if (is_octal(b)) begin
                    odig_next = 2'd1;
                    oval_next = {5'b0, b[2:0]};
                  end else begin
                    res[cnt[0]] = mk_res(KIND_BYTE, b);
                    cnt = cnt + 2'd1;
                  end
                end
              endcase
            end else if (b == CH_LPAREN) begin
              // nest deeper, saturating
              if (depth < MAX_D) depth_next = depth + ONE_D;
              res[cnt[0]] = mk_res(KIND_BYTE, b);
              cnt = cnt + 2'd1;
            end else if (b == CH_RPAREN) begin
              dec = (depth != '0) ? depth - ONE_D : '0;
              if (dec != '0) begin
                depth_next = dec;
                res[cnt[0]] = mk_res(KIND_BYTE, b);
                cnt = cnt + 2'd1;
              end else begin
                res[cnt[0]] = mk_res(KIND_END, 8'h00);
                cnt = cnt + 2'd1;
                clr = 1'b1;
              end
            end else if (b == CH_BSLASH) begin
              esc_next = 1'b1;
            end else begin
              res[cnt[0]] = mk_res(KIND_BYTE, b);
              cnt = cnt + 2'd1;
            end
          end
        end
      end
      MODE_HEX: begin
        if (flush || (b == CH_GT)) begin
          // close: give a lone nibble, then the end
          if (pend) begin
            res[cnt[0]] = mk_res(KIND_BYTE, {hi, 4'h0});
            cnt = cnt + 2'd1;
          end
          res[cnt[0]] = mk_res(KIND_END, 8'h00);
          cnt = cnt + 2'd1;
          clr = 1'b1;
        end else if (is_white(b)) begin
          cnt = 2'd0;
        end else if (hv[4]) begin
          res[cnt[0]] = mk_res(KIND_REJ, 8'h00);
          cnt = cnt + 2'd1;
        end else if (pend) begin
          res[cnt[0]] = mk_res(KIND_BYTE, {hi, hv[3:0]});
          cnt = cnt + 2'd1;
          pend_next = 1'b0;
          hi_next = 4'h0;
        end else begin
          hi_next = hv[3:0];
          pend_next = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        if (flush) begin
          res[cnt[0]] = mk_res(KIND_REJ, 8'h00);
          cnt = cnt + 2'd1;
        end else if (is_white(b)) begin
          cnt = 2'd0;
        end else if (b == CH_LPAREN) begin
          clr = 1'b1;
        end else if (b == CH_LT) begin
          clr = 1'b1;
        end else begin
          res[cnt[0]] = mk_res(KIND_REJ, 8'h00);
          cnt = cnt + 2'd1;
        end
      end
    endcase
    // return to the reset state, then enter a new string if one opened
    if (clr) begin
      mode_next  = MODE_IDLE;
      depth_next = '0;
      esc_next   = 1'b0;
      odig_next  = 2'd0;
      oval_next  = 8'h00;
      hi_next    = 4'h0;
      pend_next  = 1'b0;
      if (mode != MODE_LIT && mode != MODE_HEX && !flush) begin
        if (b == CH_LPAREN) begin
          mode_next  = MODE_LIT;
          depth_next = ONE_D;
        end else begin
          mode_next  = MODE_HEX;
        end
      end
    end
    res[0].last = (cnt == 2'd1);
    res[1].last = 1'b1;
  end

  // Queue the results of an accepted byte
  assign q_push    = accept && (cnt != 2'd0);
  assign q_data.two = (cnt == 2'd2);
  assign q_data.r0 = res[0];
  assign q_data.r1 = res[1];

  // State registers: advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      depth <= '0;
      esc   <= 1'b0;
      odig  <= 2'd0;
      oval  <= 8'h00;
      hi    <= 4'h0;
      pend  <= 1'b0;
    end else if (accept) begin
      mode  <= mode_next;
      depth <= depth_next;
      esc   <= esc_next;
      odig  <= odig_next;
      oval  <= oval_next;
      hi    <= hi_next;
      pend  <= pend_next;
    end
  end

`ifndef SYNTH
  a_octal_in_literal: assert property (@(posedge clk) disable iff (rst)
    (odig != 2'd0) |-> (mode == MODE_LIT && !esc && odig != 2'd3))
    else $error("octal escape state outside literal mode");
  a_nibble_in_hex: assert property (@(posedge clk) disable iff (rst)
    pend |-> (mode == MODE_HEX))
    else $error("pending nibble outside hex mode");
  a_depth_in_literal: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_LIT) |-> (depth == '0 && !esc))
    else $error("nesting state outside literal mode");
`endif

endmodule

/* rtl/psd_queue.sv */
// Result queue between the decode front end and the output back end.
module psd_queue import psd_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output qentry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

  qentry_t       mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_C);
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  // Store an entry
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == LAST_P) ? '0 : wptr + PW'(1);
      if (pop)  rptr <= (rptr == LAST_P) ? '0 : rptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_C)
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> !full)
    else $error("push into full queue");
`endif

endmodule

/* rtl/psd_back.sv */
// Back end: splits queued entries into single results behind an output register.
module psd_back import psd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  qentry_t       head,
  output logic          pop,
  psd_stream_if.source  out_res
);

  logic out_valid;
  res_t out_data;
  logic phase;
  logic load;

  assign out_res.valid = out_valid;
  assign out_res.data  = out_data;

  // Load when the output register is empty or being taken
  assign load = (!out_valid || out_res.ready) && head_valid;
  assign pop  = load && (phase || !head.two);

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) out_data <= phase ? head.r1 : head.r0;
  end

  // Output valid and second-result phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !phase && head.two;
      end else if (out_res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/pdf_string_token_decoder.sv */
// Top level of the PDF string token decoder: front end, result queue, back end.
//
//  channel   dir  payload                     transaction
//  in_tok    in   action, in_byte             in_tok.valid && in_tok.ready
//  out_res   out  kind, out_byte, last        out_res.valid && out_res.ready
//
// One input byte is accepted per cycle while the result queue has room.
// Each byte yields zero, one or two results; the output register gives one
// result per cycle while out_res.ready is high, so a byte with two results
// gives them one after the other. The first result of a byte passes through
// the result queue and then the output register before it is offered.
// Synchronous reset returns the decoder to idle and empties the queue.
// A stalled output fills the queue, then drops in_tok.ready.
module pdf_string_token_decoder import psd_pkg::*; #(
  parameter int MAX_NEST    = MAX_NEST_DEF,
  parameter int QUEUE_DEPTH = QDEPTH
) (
  input  logic          clk,
  input  logic          rst,
  psd_stream_if.sink    in_tok,
  psd_stream_if.source  out_res
);

  logic    q_full;
  logic    q_push;
  qentry_t q_in;
  logic    q_pop;
  logic    q_valid;
  qentry_t q_head;

  psd_front #(.MAX_NEST(MAX_NEST)) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_tok (in_tok),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  psd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  psd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_res    (out_res)
  );

endmodule
